[rtl/core/bavg_pkg.sv]
// shared types and constants of the block average downscaler
// depends on nothing; all other files but bavg_ram refer to it by scoped names
package bavg_pkg;

    // limits
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_BLOCK = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // register widths and reset values
    localparam int BS_W     = 5;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam logic [BS_W-1:0]     BS_RESET     = 5'd10;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd2048;

    // datapath widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 13;
    localparam int TIL_W  = 4;
    localparam int TCOL_W = 11;
    localparam int CSUM_W = 12;
    localparam int RSUM_W = 16;
    localparam int AREA_W = 9;

    // serial divider
    localparam int DIV_N_W   = 16;
    localparam int DIV_D_W   = 9;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_go;
        logic cfg_latch;
        logic accept;
        logic acc;
        logic div_go;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic tile_done;
        logic out_busy;
    } sts_t;

endpackage

[rtl/core/bavg_ram.sv]
// generic single write port ram with registered read
// no dependencies
module bavg_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bavg_div.sv]
// restoring serial divider, one quotient bit per cycle
// depends on bavg_pkg
module bavg_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bavg_pkg::DIV_N_W-1:0]    dividend,
    input  logic [bavg_pkg::DIV_D_W-1:0]    divisor,
    output logic [bavg_pkg::DIV_N_W-1:0]    quotient,
    output logic                            done
);

    logic [bavg_pkg::DIV_N_W-1:0]   dvd_reg;
    logic [bavg_pkg::DIV_D_W-1:0]   rem_reg;
    logic [bavg_pkg::DIV_D_W-1:0]   dsr_reg;
    logic [bavg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [bavg_pkg::DIV_D_W:0]     shifted;
    logic [bavg_pkg::DIV_D_W:0]     diff;
    logic                           ge;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[bavg_pkg::DIV_N_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == bavg_pkg::DIV_LAST);
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bavg_pkg::DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operands, quotient shifts in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[bavg_pkg::DIV_D_W-1:0] : shifted[bavg_pkg::DIV_D_W-1:0];
            dvd_reg <= {dvd_reg[bavg_pkg::DIV_N_W-2:0], ge};
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[rtl/core/bavg_dpath.sv]
// datapath: config registers, position counters, column sum ram, tile sums,
// dividers and the output register; depends on bavg_pkg, bavg_ram, bavg_div
module bavg_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bavg_pkg::cmd_t                    cmd,
    output bavg_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start_of_frame,
    input  logic [bavg_pkg::PIX_W-1:0]        red_in,
    input  logic [bavg_pkg::PIX_W-1:0]        green_in,
    input  logic [bavg_pkg::PIX_W-1:0]        blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bavg_pkg::PIX_W-1:0]        red_avg,
    output logic [bavg_pkg::PIX_W-1:0]        green_avg,
    output logic [bavg_pkg::PIX_W-1:0]        blue_avg,
    output logic                              end_of_out_row,
    output logic                              end_of_out_frame
);

    localparam int RAM_W = 3 * bavg_pkg::CSUM_W;

    // config registers and derived geometry
    logic [bavg_pkg::BS_W-1:0]     bs_reg;
    logic [bavg_pkg::WIDTH_W-1:0]  w_reg;
    logic [bavg_pkg::HEIGHT_W-1:0] h_reg;
    logic [bavg_pkg::BS_W-1:0]     bs_eff;
    logic [bavg_pkg::WIDTH_W-1:0]  w_eff;
    logic [bavg_pkg::HEIGHT_W-1:0] h_eff;
    logic [bavg_pkg::WIDTH_W-1:0]  tiles_x_reg;
    logic [bavg_pkg::WIDTH_W-1:0]  full_w_reg;
    logic [bavg_pkg::HEIGHT_W-1:0] full_h_reg;
    logic [bavg_pkg::AREA_W-1:0]   area_reg;
    logic [16:0]                   fw_prod;
    logic [17:0]                   fh_prod;
    logic [bavg_pkg::AREA_W-1:0]   area_prod;

    // counters
    logic [bavg_pkg::COL_W-1:0]  col_reg;
    logic [bavg_pkg::ROW_W-1:0]  row_reg;
    logic [bavg_pkg::TIL_W-1:0]  cit_reg;
    logic [bavg_pkg::TIL_W-1:0]  rit_reg;
    logic [bavg_pkg::TCOL_W-1:0] tcol_reg;

    // pixel and sums
    logic [bavg_pkg::PIX_W-1:0]  px_reg   [3];
    logic [bavg_pkg::RSUM_W-1:0] rrs_reg  [3];
    logic [bavg_pkg::CSUM_W-1:0] cs_old   [3];
    logic [bavg_pkg::CSUM_W-1:0] cs_new   [3];
    logic [RAM_W-1:0]            ram_rdata;
    logic [RAM_W-1:0]            ram_wdata;
    logic [bavg_pkg::COL_W-1:0]  ram_raddr;
    logic                        ram_we;

    // tile decisions
    logic in_full;
    logic last_r;
    logic last_c;
    logic eor_now;
    logic eof_now;
    logic eor_reg;
    logic eof_reg;

    // dividers
    logic [bavg_pkg::DIV_N_W-1:0] div_n [3];
    logic [bavg_pkg::DIV_D_W-1:0] div_d;
    logic [bavg_pkg::DIV_N_W-1:0] div_q [3];
    logic [2:0]                   div_done;
    logic                         div_start;

    // output register
    logic                       out_valid_reg;
    logic [bavg_pkg::PIX_W-1:0] avg_reg [3];
    logic                       oeor_reg;
    logic                       oeof_reg;

    // register clamping
    always_comb
    begin
        if (bs_reg == '0)
            bs_eff = bavg_pkg::BS_W'(1);
        else if (bs_reg > bavg_pkg::BS_W'(bavg_pkg::MAX_BLOCK))
            bs_eff = bavg_pkg::BS_W'(bavg_pkg::MAX_BLOCK);
        else
            bs_eff = bs_reg;
        if (w_reg == '0)
            w_eff = bavg_pkg::WIDTH_W'(1);
        else if (w_reg > bavg_pkg::WIDTH_W'(bavg_pkg::MAX_WIDTH))
            w_eff = bavg_pkg::WIDTH_W'(bavg_pkg::MAX_WIDTH);
        else
            w_eff = w_reg;
        h_eff = (h_reg == '0) ? bavg_pkg::HEIGHT_W'(1) : h_reg;
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= bavg_pkg::BS_RESET;
            w_reg  <= bavg_pkg::WIDTH_RESET;
            h_reg  <= bavg_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bavg_pkg::CFG_BLOCK_SIZE:   bs_reg <= cfg_data[bavg_pkg::BS_W-1:0];
                bavg_pkg::CFG_IMAGE_WIDTH:  w_reg  <= cfg_data[bavg_pkg::WIDTH_W-1:0];
                bavg_pkg::CFG_IMAGE_HEIGHT: h_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry from the divider quotients
    always_comb
    begin
        fw_prod   = {5'd0, div_q[0][bavg_pkg::WIDTH_W-1:0]} * {12'd0, bs_eff};
        fh_prod   = {5'd0, div_q[1][bavg_pkg::HEIGHT_W-1:0]} * {13'd0, bs_eff};
        area_prod = {4'd0, bs_eff} * {4'd0, bs_eff};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cfg_latch)
        begin
            tiles_x_reg <= div_q[0][bavg_pkg::WIDTH_W-1:0];
            full_w_reg  <= fw_prod[bavg_pkg::WIDTH_W-1:0];
            full_h_reg  <= fh_prod[bavg_pkg::HEIGHT_W-1:0];
            area_reg    <= area_prod;
        end
    end

    // column sum ram
    assign ram_raddr = start_of_frame ? '0 : col_reg;

    always_comb
    begin
        cs_old[0] = ram_rdata[bavg_pkg::CSUM_W-1:0];
        cs_old[1] = ram_rdata[2*bavg_pkg::CSUM_W-1:bavg_pkg::CSUM_W];
        cs_old[2] = ram_rdata[3*bavg_pkg::CSUM_W-1:2*bavg_pkg::CSUM_W];
        for (int c = 0; c < 3; c++)
        begin
            cs_new[c] = (rit_reg == '0) ? {4'd0, px_reg[c]} : cs_old[c] + {4'd0, px_reg[c]};
        end
        ram_wdata = {cs_new[2], cs_new[1], cs_new[0]};
    end

    // tile decisions for the current pixel
    always_comb
    begin
        in_full = ({1'b0, col_reg} < full_w_reg) && (row_reg < full_h_reg);
        last_r  = ({1'b0, rit_reg} + 5'd1) >= bs_eff;
        last_c  = ({1'b0, cit_reg} + 5'd1) >= bs_eff;
        eor_now = ({1'b0, tcol_reg} + 12'd1) >= tiles_x_reg;
        eof_now = eor_now && (({1'b0, row_reg} + 14'd1) >= {1'b0, full_h_reg});
        ram_we  = cmd.acc && in_full;
    end

    assign sts.tile_done = in_full && last_r && last_c;

    bavg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (bavg_pkg::MAX_WIDTH)
    ) u_colsum (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pixel capture and tile sums
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg[0] <= red_in;
            px_reg[1] <= green_in;
            px_reg[2] <= blue_in;
        end
        if (cmd.acc && in_full && last_r)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rrs_reg[c] <= (cit_reg == '0) ? {4'd0, cs_new[c]}
                                              : rrs_reg[c] + {4'd0, cs_new[c]};
            end
        end
        if (cmd.acc && sts.tile_done)
        begin
            eor_reg <= eor_now;
            eof_reg <= eof_now;
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cit_reg  <= '0;
            rit_reg  <= '0;
            tcol_reg <= '0;
        end
        else if (cmd.accept && start_of_frame)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cit_reg  <= '0;
            rit_reg  <= '0;
            tcol_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (({1'b0, col_reg} + 12'd1) >= w_eff)
            begin
                col_reg  <= '0;
                cit_reg  <= '0;
                tcol_reg <= '0;
                if (({1'b0, row_reg} + 14'd1) >= {1'b0, h_eff})
                begin
                    row_reg <= '0;
                    rit_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    rit_reg <= last_r ? '0 : rit_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                if (last_c)
                begin
                    cit_reg  <= '0;
                    tcol_reg <= tcol_reg + 1'b1;
                end
                else
                begin
                    cit_reg <= cit_reg + 1'b1;
                end
            end
        end
    end

    // divider operands: geometry on config, averages on tile end
    always_comb
    begin
        div_start = cmd.cfg_go || cmd.div_go;
        if (cmd.cfg_go)
        begin
            div_n[0] = {4'd0, w_eff};
            div_n[1] = {3'd0, h_eff};
            div_n[2] = '0;
            div_d    = {4'd0, bs_eff};
        end
        else
        begin
            div_n[0] = rrs_reg[0];
            div_n[1] = rrs_reg[1];
            div_n[2] = rrs_reg[2];
            div_d    = area_reg;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        bavg_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_n[g]),
            .divisor  (div_d),
            .quotient (div_q[g]),
            .done     (div_done[g])
        );
    end

    assign sts.div_done = div_done[0] && div_done[1] && div_done[2];

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                avg_reg[c] <= div_q[c][bavg_pkg::PIX_W-1:0];
            end
            oeor_reg <= eor_reg;
            oeof_reg <= eof_reg;
        end
    end

    assign sts.out_busy     = out_valid_reg && out_stall;
    assign out_valid        = out_valid_reg;
    assign red_avg          = avg_reg[0];
    assign green_avg        = avg_reg[1];
    assign blue_avg         = avg_reg[2];
    assign end_of_out_row   = oeor_reg;
    assign end_of_out_frame = oeof_reg;

endmodule

[rtl/core/bavg_ctrl.sv]
// controller state machine: geometry recompute, pixel accumulate, averaging
// depends on bavg_pkg
module bavg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           in_valid,
    output logic           in_stall,
    input  bavg_pkg::sts_t sts,
    output bavg_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CFG_GO   = 3'd0;
    localparam logic [2:0] ST_CFG_WAIT = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_ACC      = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // input handshake
    assign in_stall = (state_reg != ST_IDLE) || cfg_we;

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.cfg_go    = (state_reg == ST_CFG_GO);
        cmd.cfg_latch = (state_reg == ST_CFG_WAIT) && sts.div_done;
        cmd.accept    = in_valid && !in_stall;
        cmd.acc       = (state_reg == ST_ACC);
        cmd.div_go    = (state_reg == ST_DIV_GO);
        cmd.out_load  = (state_reg == ST_OUT) && !sts.out_busy;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = ST_CFG_GO;
        end
        else
        begin
            unique case (state_reg)
                ST_CFG_GO:   state_next = ST_CFG_WAIT;
                ST_CFG_WAIT: if (sts.div_done) state_next = ST_IDLE;
                ST_IDLE:     if (cmd.accept) state_next = ST_ACC;
                ST_ACC:      state_next = sts.tile_done ? ST_DIV_GO : ST_IDLE;
                ST_DIV_GO:   state_next = ST_DIV_WAIT;
                ST_DIV_WAIT: if (sts.div_done) state_next = ST_OUT;
                ST_OUT:      if (!sts.out_busy) state_next = ST_IDLE;
                default:     state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CFG_GO;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/block_average_downscale.sv]
// top level of the block average downscaler
// depends on bavg_pkg, bavg_ctrl, bavg_dpath
//
// Averages each full block_size x block_size tile of an RGB888 raster and
// emits one truncated average per tile; partial tiles at the right and bottom
// are consumed silently. Each pixel goes through a column sum ram read, then
// an update; the pixel that completes a tile also waits on the 16-step serial
// divider and on the output register. Each configuration write starts a
// geometry recompute on the same divider, during which input is stalled; the
// same recompute runs after reset.
module block_average_downscale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              start_of_frame,
    input  logic [bavg_pkg::PIX_W-1:0]        red_in,
    input  logic [bavg_pkg::PIX_W-1:0]        green_in,
    input  logic [bavg_pkg::PIX_W-1:0]        blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bavg_pkg::PIX_W-1:0]        red_avg,
    output logic [bavg_pkg::PIX_W-1:0]        green_avg,
    output logic [bavg_pkg::PIX_W-1:0]        blue_avg,
    output logic                              end_of_out_row,
    output logic                              end_of_out_frame
);

    bavg_pkg::cmd_t cmd;
    bavg_pkg::sts_t sts;

    bavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bavg_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start_of_frame   (start_of_frame),
        .red_in           (red_in),
        .green_in         (green_in),
        .blue_in          (blue_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_avg          (red_avg),
        .green_avg        (green_avg),
        .blue_avg         (blue_avg),
        .end_of_out_row   (end_of_out_row),
        .end_of_out_frame (end_of_out_frame)
    );

    // a word in progress blocks the next one
    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous word in progress");

    // geometry recompute holds off input
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input open during geometry recompute");

    // frame end is always a row end
    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_out_frame) |-> end_of_out_row)
        else $error("end of frame without end of row");

endmodule
